// ===== rtl/u8r_pkg.sv =====
// ----------------------------------------------------------------------------
// u8r_pkg
// Shared types and constants of the UTF-8 decoder with position ring.
// ----------------------------------------------------------------------------
`default_nettype none

package u8r_pkg;

  // Fixed payload widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 32;
  localparam int unsigned POS_OUT_W = 16;
  localparam int unsigned CNT_W     = 3;

  // Continuation byte detection: top two bits are 10
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  // Byte counter limits
  localparam logic [CNT_W-1:0] CNT_MAX  = 3'd7;
  localparam logic [CNT_W-1:0] CNT_LONG = 3'd6;
  localparam logic [CNT_W-1:0] IDX_LAST = 3'd5;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    KIND_CODE = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERLONG = 2'd1,
    ERR_POS_SAT  = 2'd2
  } err_e;

  // Decoder state controls
  typedef struct packed {
    logic decode;
    logic pop_load;
    logic clear;
  } dec_ctrl_t;

  // Ring controls
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  // Offset removed from the accumulated value, by sequence length minus one
  function automatic logic [CP_W-1:0] len_offset(input logic [CNT_W-1:0] idx);
    logic [CP_W-1:0] off;
    case (idx)
      3'd0:    off = 32'h0000_0000;
      3'd1:    off = 32'h0000_3080;
      3'd2:    off = 32'h000E_2080;
      3'd3:    off = 32'h03C8_2080;
      3'd4:    off = 32'hFA08_2080;
      3'd5:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8r_if.sv =====
// ----------------------------------------------------------------------------
// u8r_if
// Valid/ready channels: byte requests in, decode and pop results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8r_in_if import u8r_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] next_byte;

  modport source (output valid, output op, output data_byte, output next_byte,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input next_byte,
                  output ready);
endinterface

interface u8r_out_if import u8r_pkg::*; ();
  logic                 valid;
  logic                 ready;
  kind_e                kind;
  logic [CP_W-1:0]      code_point;
  logic [POS_OUT_W-1:0] end_position;
  logic [POS_OUT_W-1:0] resume_position;
  logic [POS_OUT_W-1:0] char_length;
  err_e                 error;

  modport source (output valid, output kind, output code_point, output end_position,
                  output resume_position, output char_length, output error,
                  input ready);
  modport sink   (input valid, input kind, input code_point, input end_position,
                  input resume_position, input char_length, input error,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/u8r_decode.sv =====
// ----------------------------------------------------------------------------
// u8r_decode
// Code-point accumulator, byte counter and byte position of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module u8r_decode import u8r_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire dec_ctrl_t                ctrl_i,
  input  wire logic [BYTE_W-1:0]        data_byte_i,
  input  wire logic [BYTE_W-1:0]        next_byte_i,
  input  wire logic [POSITION_BITS-1:0] pos_load_i,
  output logic                          end_seq_o,
  output logic [CP_W-1:0]               code_point_o,
  output logic [POSITION_BITS-1:0]      pos_o,
  output err_e                          error_o
);

  logic [CP_W-1:0]          acc_q, acc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  logic [CP_W-1:0]          acc_next;
  logic [CNT_W-1:0]         cnt_next;
  logic [CNT_W-1:0]         len_idx;
  logic                     pos_sat;
  logic                     overlong;

  // Shift in six bits, count the byte, advance the position
  always_comb begin
    acc_next = {acc_q[CP_W-7:0], 6'b0} + CP_W'(data_byte_i);
    cnt_next = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
    pos_sat  = (pos_q == '1);
    pos_o    = pos_sat ? pos_q : pos_q + 1'b1;
    overlong = (cnt_next > CNT_LONG);
    len_idx  = overlong ? IDX_LAST : cnt_next - 1'b1;
    end_seq_o    = (next_byte_i == '0) || ((next_byte_i & CONT_MASK) != CONT_TAG);
    code_point_o = acc_next - len_offset(len_idx);
    if (overlong) begin
      error_o = ERR_OVERLONG;
    end else if (pos_sat) begin
      error_o = ERR_POS_SAT;
    end else begin
      error_o = ERR_NONE;
    end
  end

  // Next state: clear, consume a byte, or take the position after a pop
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      cnt_d = '0;
      pos_d = '0;
    end else if (ctrl_i.decode) begin
      acc_d = end_seq_o ? '0 : acc_next;
      cnt_d = end_seq_o ? '0 : cnt_next;
      pos_d = pos_o;
    end else if (ctrl_i.pop_load) begin
      pos_d = pos_load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8r_ring.sv =====
// ----------------------------------------------------------------------------
// u8r_ring
// Wrapping ring of end positions with cached top, previous and
// second-previous entries; the second-previous one is prefetched from memory.
// ----------------------------------------------------------------------------
`default_nettype none

module u8r_ring import u8r_pkg::*; #(
  parameter int unsigned RING_SLOTS    = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ring_ctrl_t               ctrl_i,
  input  wire logic [POSITION_BITS-1:0] push_pos_i,
  output logic                          valid_o,
  output logic [POSITION_BITS-1:0]      top_val_o,
  output logic [POSITION_BITS-1:0]      prev_val_o,
  output logic [POSITION_BITS-1:0]      prev2_val_o
);

  localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_LAST : s - 1'b1;
  endfunction

  logic [POSITION_BITS-1:0] mem [RING_SLOTS];
  logic [RING_SLOTS-1:0]    ent_vld_q, ent_vld_d;

  logic [SLOT_W-1:0]        top_q, top_d;
  logic                     valid_q, valid_d;
  logic [POSITION_BITS-1:0] top_val_q, top_val_d;
  logic [POSITION_BITS-1:0] prev_val_q, prev_val_d;

  logic                     wr_en;
  logic [SLOT_W-1:0]        rd_addr;
  logic [POSITION_BITS-1:0] rd_data_q;
  logic                     rd_vld_q;
  logic                     rd_zero_q;
  logic                     byp_q;
  logic [POSITION_BITS-1:0] byp_data_q;
  logic                     do_pop;

  // Second-previous entry: cleared, bypassed from a write, stored or never written
  always_comb begin
    if (rd_zero_q) begin
      prev2_val_o = '0;
    end else if (byp_q) begin
      prev2_val_o = byp_data_q;
    end else if (rd_vld_q) begin
      prev2_val_o = rd_data_q;
    end else begin
      prev2_val_o = '0;
    end
  end

  // Next ring state
  always_comb begin
    do_pop     = ctrl_i.pop && valid_q;
    top_d      = top_q;
    valid_d    = valid_q;
    top_val_d  = top_val_q;
    prev_val_d = prev_val_q;
    ent_vld_d  = ent_vld_q;
    wr_en      = 1'b0;
    if (ctrl_i.clear) begin
      top_d      = '0;
      valid_d    = 1'b0;
      top_val_d  = '0;
      prev_val_d = '0;
      ent_vld_d  = '0;
    end else if (ctrl_i.push) begin
      top_d      = valid_q ? slot_inc(top_q) : '0;
      valid_d    = 1'b1;
      top_val_d  = push_pos_i;
      prev_val_d = top_val_q;
      wr_en      = 1'b1;
      ent_vld_d[top_d] = 1'b1;
    end else if (do_pop) begin
      top_d      = slot_dec(top_q);
      top_val_d  = prev_val_q;
      prev_val_d = prev2_val_o;
    end
    rd_addr = slot_dec(slot_dec(top_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      valid_q    <= 1'b0;
      top_val_q  <= '0;
      prev_val_q <= '0;
      ent_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      rd_zero_q  <= 1'b1;
      byp_q      <= 1'b0;
    end else begin
      top_q      <= top_d;
      valid_q    <= valid_d;
      top_val_q  <= top_val_d;
      prev_val_q <= prev_val_d;
      ent_vld_q  <= ent_vld_d;
      rd_vld_q   <= ent_vld_q[rd_addr];
      rd_zero_q  <= ctrl_i.clear;
      byp_q      <= wr_en && (rd_addr == top_d);
    end
  end

  // Write the pushed position, prefetch the entry behind the new previous one
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[top_d] <= push_pos_i;
    end
    rd_data_q  <= mem[rd_addr];
    byp_data_q <= push_pos_i;
  end

  assign valid_o    = valid_q;
  assign top_val_o  = top_val_q;
  assign prev_val_o = prev_val_q;

endmodule

`default_nettype wire

// ===== rtl/utf8_decoder_with_position_ring_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_with_position_ring_unit
// UTF-8 byte decoder that pushes each character's end position into a
// wrapping ring; pops step the ring back, a clear empties everything.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat fields
//  -------  ---  ---------------------------------------------------------------
//  in_i     in   op, data_byte, next_byte
//  out_o    out  kind, code_point, end_position, resume_position, char_length, error
//
//  One beat per cycle while out_o does not stall; a result is valid on out_o
//  once its request beat has passed the input register and then the result
//  register. The ring update and the decode arithmetic both fit between those
//  two registers.
//  Reset clears the ring, accumulator and position at once; no sweep.
//  An output stall holds the request stage; in_i.ready drops only while
//  both the request stage and the result register are full and out_o stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_with_position_ring_unit import u8r_pkg::*; #(
  parameter int unsigned RING_SLOTS    = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  u8r_in_if.sink    in_i,
  u8r_out_if.source out_o
);

  // Request stage
  logic              in_vld_q;
  op_e               op_q;
  logic [BYTE_W-1:0] data_byte_q;
  logic [BYTE_W-1:0] next_byte_q;

  // Result register
  logic                 out_vld_q;
  kind_e                kind_q, kind_d;
  logic [CP_W-1:0]      cp_q, cp_d;
  logic [POS_OUT_W-1:0] end_pos_q, end_pos_d;
  logic [POS_OUT_W-1:0] resume_q, resume_d;
  logic [POS_OUT_W-1:0] len_q, len_d;
  err_e                 err_q, err_d;

  logic       go;
  logic       proc;
  logic       has_result;
  dec_ctrl_t  dec_ctrl;
  ring_ctrl_t ring_ctrl;

  logic                     end_seq;
  logic [CP_W-1:0]          dec_cp;
  logic [POSITION_BITS-1:0] dec_pos;
  err_e                     dec_err;

  logic                     ring_vld;
  logic [POSITION_BITS-1:0] top_val;
  logic [POSITION_BITS-1:0] prev_val;
  logic [POSITION_BITS-1:0] prev2_val;

  // Advance when the result register is free or being drained
  assign go         = !out_vld_q || out_o.ready;
  assign proc       = in_vld_q && go;
  assign in_i.ready = !in_vld_q || go;

  always_comb begin
    has_result         = ((op_q == OP_DECODE) && end_seq) || (op_q == OP_POP);
    dec_ctrl.decode    = proc && (op_q == OP_DECODE);
    dec_ctrl.pop_load  = proc && (op_q == OP_POP) && ring_vld;
    dec_ctrl.clear     = proc && (op_q == OP_CLEAR);
    ring_ctrl.push     = proc && (op_q == OP_DECODE) && end_seq;
    ring_ctrl.pop      = proc && (op_q == OP_POP);
    ring_ctrl.clear    = proc && (op_q == OP_CLEAR);
  end

  u8r_decode #(
    .POSITION_BITS (POSITION_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dec_ctrl),
    .data_byte_i  (data_byte_q),
    .next_byte_i  (next_byte_q),
    .pos_load_i   (prev_val),
    .end_seq_o    (end_seq),
    .code_point_o (dec_cp),
    .pos_o        (dec_pos),
    .error_o      (dec_err)
  );

  u8r_ring #(
    .RING_SLOTS    (RING_SLOTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ring_ctrl),
    .push_pos_i  (dec_pos),
    .valid_o     (ring_vld),
    .top_val_o   (top_val),
    .prev_val_o  (prev_val),
    .prev2_val_o (prev2_val)
  );

  // Build the result beat
  always_comb begin
    if (op_q == OP_POP) begin
      kind_d = KIND_POP;
      cp_d   = '0;
      err_d  = ERR_NONE;
      if (ring_vld) begin
        end_pos_d = POS_OUT_W'(top_val);
        resume_d  = POS_OUT_W'(prev_val);
        len_d     = (prev_val >= prev2_val) ? POS_OUT_W'(prev_val - prev2_val) : '0;
      end else begin
        end_pos_d = '0;
        resume_d  = '0;
        len_d     = '0;
      end
    end else begin
      kind_d    = KIND_CODE;
      cp_d      = dec_cp;
      err_d     = dec_err;
      end_pos_d = POS_OUT_W'(dec_pos);
      resume_d  = POS_OUT_W'(dec_pos);
      len_d     = (dec_pos >= top_val) ? POS_OUT_W'(dec_pos - top_val) : '0;
    end
  end

  // Request stage and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (go) begin
        out_vld_q <= in_vld_q && has_result;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q        <= in_i.op;
      data_byte_q <= in_i.data_byte;
      next_byte_q <= in_i.next_byte;
    end
    if (proc && has_result) begin
      kind_q    <= kind_d;
      cp_q      <= cp_d;
      end_pos_q <= end_pos_d;
      resume_q  <= resume_d;
      len_q     <= len_d;
      err_q     <= err_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.kind            = kind_q;
  assign out_o.code_point      = cp_q;
  assign out_o.end_position    = end_pos_q;
  assign out_o.resume_position = resume_q;
  assign out_o.char_length     = len_q;
  assign out_o.error           = err_q;

  // A processed clear leaves the ring empty
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_ctrl.clear |=> !ring_vld)
    else $error("ring still valid after clear");

  // A push always leaves the ring holding an entry
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_ctrl.push |=> ring_vld && (top_val == $past(dec_pos)))
    else $error("pushed position not at ring top");

  // A stalled request is held in place
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !go |=> in_vld_q && $stable(op_q))
    else $error("request stage lost while stalled");

  // A pop result on an empty ring carries no position
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (op_q == OP_POP) && !ring_vld |=> out_vld_q && (end_pos_q == '0))
    else $error("pop on empty ring returned a position");

endmodule

`default_nettype wire
